// ===== src/tbl_pkg.sv =====
package tbl_pkg;

  localparam int ADC_BITS   = 12;
  localparam int IN_TDATA_W = ((ADC_BITS + 7) / 8) * 8;
  localparam logic [ADC_BITS-1:0] FULL_CODE = '1;

  localparam int RES_W      = 20;
  localparam int BETA_W     = 16;
  localparam int TEMP_W     = 8;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [RES_W-1:0]  SERIES_RST  = 20'd10000;
  localparam logic [RES_W-1:0]  NOMINAL_RST = 20'd10000;
  localparam logic [BETA_W-1:0] BETA_RST    = 16'd3950;
  localparam logic [TEMP_W-1:0] T0_RST      = 8'd25;

  // log2 lanes: operand, exponent, fraction, mantissa
  localparam int OP_W       = 20;
  localparam int K_W        = 5;
  localparam int FRAC_W     = 40;
  localparam int M_W        = 63;
  localparam int LOG_W      = K_W + FRAC_W;
  localparam int ITERS      = 40;
  localparam int LOG_STAGES = 1 + 2 * ITERS;

  // scaling and division
  localparam int SUM_W        = LOG_W + 1;
  localparam int LSUM_W       = LOG_W + 2;
  localparam int XM_W         = 38;
  localparam int T0H_W        = 16;
  localparam int B100_W       = 23;
  localparam int NUM_W        = 39;
  localparam int D_W          = 57;
  localparam int DMAG_W       = 56;
  localparam int REM_W        = 57;
  localparam int Q_W          = 32;
  localparam int SCALE_STAGES = 9;
  localparam int DIV_STAGES   = Q_W;
  localparam int PIPE_STAGES  = 1 + LOG_STAGES + SCALE_STAGES + DIV_STAGES;

  localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;
  localparam int KELVIN_CENTI = 27315;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERIES  = 2'd0,
    REG_NOMINAL = 2'd1,
    REG_BETA    = 2'd2,
    REG_T0      = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_ZERO_R  = 3'd1,
    KIND_DZERO   = 3'd2,
    KIND_OVF_POS = 3'd3,
    KIND_OVF_NEG = 3'd4
  } kind_e;

  typedef struct packed {
    logic [T0H_W-1:0]  t0h;
    logic [B100_W-1:0] b100;
    logic [NUM_W-1:0]  num;
  } cfg_t;

endpackage

// ===== src/tbl_log_lane.sv =====
// log2 with 40 fraction bits: normalize, then one truncated squaring per
// two stages (partial products, then sum and renormalize).
module tbl_log_lane (
  input  logic                       clk_i,
  input  logic                       adv_i,
  input  logic [tbl_pkg::OP_W-1:0]   op_i,
  output logic [tbl_pkg::LOG_W-1:0]  log_o
);

  logic [tbl_pkg::OP_W-1:0] opn;
  logic [tbl_pkg::K_W-1:0]  k_d;
  logic [5:0]               sh;

  logic [tbl_pkg::M_W-1:0]    m_q   [0:tbl_pkg::ITERS];
  logic [tbl_pkg::K_W-1:0]    k_q   [0:tbl_pkg::ITERS];
  logic [tbl_pkg::FRAC_W-1:0] f_q   [0:tbl_pkg::ITERS];
  logic [61:0]                p11_q [0:tbl_pkg::ITERS-1];
  logic [62:0]                p10_q [0:tbl_pkg::ITERS-1];
  logic [63:0]                p00_q [0:tbl_pkg::ITERS-1];
  logic [tbl_pkg::K_W-1:0]    ka_q  [0:tbl_pkg::ITERS-1];
  logic [tbl_pkg::FRAC_W-1:0] fa_q  [0:tbl_pkg::ITERS-1];
  logic [63:0]                m2    [0:tbl_pkg::ITERS-1];

  always_comb begin
    opn = (op_i == '0) ? tbl_pkg::OP_W'(1) : op_i;
    k_d = '0;
    for (int b = 0; b < tbl_pkg::OP_W; b++) begin
      if (opn[b]) k_d = tbl_pkg::K_W'(b);
    end
    sh = 6'd62 - 6'(k_d);
  end

  always_comb begin
    for (int i = 0; i < tbl_pkg::ITERS; i++) begin
      m2[i] = 64'(({p11_q[i], 64'd0} + 126'({p10_q[i], 33'd0}) + 126'(p00_q[i])) >> 62);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      m_q[0] <= tbl_pkg::M_W'(opn) << sh;
      k_q[0] <= k_d;
      f_q[0] <= '0;
      for (int i = 0; i < tbl_pkg::ITERS; i++) begin
        p11_q[i]  <= 62'(m_q[i][62:32]) * 62'(m_q[i][62:32]);
        p10_q[i]  <= 63'(m_q[i][62:32]) * 63'(m_q[i][31:0]);
        p00_q[i]  <= 64'(m_q[i][31:0]) * 64'(m_q[i][31:0]);
        ka_q[i]   <= k_q[i];
        fa_q[i]   <= f_q[i];
        m_q[i+1]  <= m2[i][63] ? m2[i][63:1] : m2[i][62:0];
        k_q[i+1]  <= ka_q[i];
        f_q[i+1]  <= {fa_q[i][tbl_pkg::FRAC_W-2:0], m2[i][63]};
      end
    end
  end

  assign log_o = {k_q[tbl_pkg::ITERS], f_q[tbl_pkg::ITERS]};

endmodule

// ===== src/tbl_scale.sv =====
// Combine logs, scale by ln2, form denominator D, flag zero and overflow.
module tbl_scale (
  input  logic                        clk_i,
  input  logic                        adv_i,
  input  tbl_pkg::cfg_t               cfg_i,
  input  tbl_pkg::kind_e              kind_i,
  input  logic [tbl_pkg::LOG_W-1:0]   lg_series_i,
  input  logic [tbl_pkg::LOG_W-1:0]   lg_rest_i,
  input  logic [tbl_pkg::LOG_W-1:0]   lg_code_i,
  input  logic [tbl_pkg::LOG_W-1:0]   lg_nom_i,
  output tbl_pkg::kind_e              kind_o,
  output logic                        dneg_o,
  output logic [tbl_pkg::DMAG_W-1:0]  dmag_o
);

  tbl_pkg::kind_e kind_q [1:tbl_pkg::SCALE_STAGES];

  logic [tbl_pkg::SUM_W-1:0]  a1_q, b1_q;
  logic [tbl_pkg::LSUM_W-1:0] l2_q;
  logic                       neg_q [3:6];
  logic [tbl_pkg::SUM_W-1:0]  mag3_q;
  logic [63:0]                pll_q, plh_q;
  logic [45:0]                phl_q, phh_q;
  logic [tbl_pkg::XM_W-1:0]   xm5_q;
  logic [34:0]                plo6_q, phi6_q;
  logic [tbl_pkg::D_W-1:0]    d7_q;
  logic                       dneg_q [8:9];
  logic                       dz8_q;
  logic [tbl_pkg::DMAG_W-1:0] dmag_q [8:9];

  logic [109:0]               prod;
  logic [53:0]                xp;
  logic [54:0]                b100s;
  logic [tbl_pkg::D_W-1:0]    d_d;
  tbl_pkg::kind_e             kind9_d;

  always_comb begin
    prod  = {phh_q, 64'd0} + 110'({plh_q, 32'd0}) + 110'({phl_q, 32'd0}) + 110'(pll_q);
    xp    = 54'({phi6_q, 19'd0}) + 54'(plo6_q);
    b100s = {cfg_i.b100, 32'd0};
    d_d   = neg_q[6] ? (tbl_pkg::D_W'(b100s) - tbl_pkg::D_W'(xp))
                     : (tbl_pkg::D_W'(b100s) + tbl_pkg::D_W'(xp));
    kind9_d = kind_q[8];
    if (kind_q[8] == tbl_pkg::KIND_NONE) begin
      if (dz8_q) begin
        kind9_d = tbl_pkg::KIND_DZERO;
      end else if (tbl_pkg::DMAG_W'(cfg_i.num) >= dmag_q[8]) begin
        kind9_d = dneg_q[8] ? tbl_pkg::KIND_OVF_NEG : tbl_pkg::KIND_OVF_POS;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      kind_q[1] <= kind_i;
      for (int s = 2; s <= 8; s++) kind_q[s] <= kind_q[s-1];
      kind_q[9] <= kind9_d;
      // sum the log terms
      a1_q <= tbl_pkg::SUM_W'(lg_series_i) + tbl_pkg::SUM_W'(lg_rest_i);
      b1_q <= tbl_pkg::SUM_W'(lg_code_i) + tbl_pkg::SUM_W'(lg_nom_i);
      l2_q <= {1'b0, a1_q} - {1'b0, b1_q};
      neg_q[3] <= l2_q[tbl_pkg::LSUM_W-1];
      mag3_q   <= l2_q[tbl_pkg::LSUM_W-1] ? tbl_pkg::SUM_W'(-l2_q)
                                          : l2_q[tbl_pkg::SUM_W-1:0];
      for (int s = 4; s <= 6; s++) neg_q[s] <= neg_q[s-1];
      // magnitude times ln2 in four partial products
      pll_q <= 64'(mag3_q[31:0]) * 64'(tbl_pkg::LN2_Q64[31:0]);
      plh_q <= 64'(mag3_q[31:0]) * 64'(tbl_pkg::LN2_Q64[63:32]);
      phl_q <= 46'(mag3_q[45:32]) * 46'(tbl_pkg::LN2_Q64[31:0]);
      phh_q <= 46'(mag3_q[45:32]) * 46'(tbl_pkg::LN2_Q64[63:32]);
      xm5_q <= prod[109:72];
      plo6_q <= 35'(xm5_q[18:0]) * 35'(cfg_i.t0h);
      phi6_q <= 35'(xm5_q[37:19]) * 35'(cfg_i.t0h);
      d7_q   <= d_d;
      dneg_q[8] <= d7_q[tbl_pkg::D_W-1];
      dz8_q     <= (d7_q == '0);
      dmag_q[8] <= d7_q[tbl_pkg::D_W-1] ? tbl_pkg::DMAG_W'(-d7_q)
                                        : d7_q[tbl_pkg::DMAG_W-1:0];
      dneg_q[9] <= dneg_q[8];
      dmag_q[9] <= dmag_q[8];
    end
  end

  assign kind_o = kind_q[9];
  assign dneg_o = dneg_q[9];
  assign dmag_o = dmag_q[9];

endmodule

// ===== src/tbl_div.sv =====
// Restoring division N*2^32 / |D|, one quotient bit per stage.
module tbl_div (
  input  logic                        clk_i,
  input  logic                        adv_i,
  input  logic [tbl_pkg::NUM_W-1:0]   num_i,
  input  tbl_pkg::kind_e              kind_i,
  input  logic                        dneg_i,
  input  logic [tbl_pkg::DMAG_W-1:0]  dmag_i,
  output tbl_pkg::kind_e              kind_o,
  output logic                        dneg_o,
  output logic [tbl_pkg::Q_W-1:0]     quot_o,
  output logic                        rem_nz_o
);

  logic [tbl_pkg::REM_W-1:0]  r_q    [1:tbl_pkg::DIV_STAGES];
  logic [tbl_pkg::Q_W-1:0]    q_q    [1:tbl_pkg::DIV_STAGES];
  logic [tbl_pkg::DMAG_W-1:0] dmag_q [1:tbl_pkg::DIV_STAGES];
  logic                       dneg_q [1:tbl_pkg::DIV_STAGES];
  tbl_pkg::kind_e             kind_q [1:tbl_pkg::DIV_STAGES];

  logic [tbl_pkg::REM_W-1:0]  r_in   [0:tbl_pkg::DIV_STAGES-1];
  logic [tbl_pkg::Q_W-1:0]    q_in   [0:tbl_pkg::DIV_STAGES-1];
  logic [tbl_pkg::DMAG_W-1:0] m_in   [0:tbl_pkg::DIV_STAGES-1];
  logic [tbl_pkg::REM_W-1:0]  r2     [0:tbl_pkg::DIV_STAGES-1];
  logic                       ge     [0:tbl_pkg::DIV_STAGES-1];

  always_comb begin
    for (int s = 0; s < tbl_pkg::DIV_STAGES; s++) begin
      if (s == 0) begin
        r_in[s] = tbl_pkg::REM_W'(num_i);
        q_in[s] = '0;
        m_in[s] = dmag_i;
      end else begin
        r_in[s] = r_q[s];
        q_in[s] = q_q[s];
        m_in[s] = dmag_q[s];
      end
      r2[s] = {r_in[s][tbl_pkg::REM_W-2:0], 1'b0};
      ge[s] = r2[s] >= tbl_pkg::REM_W'(m_in[s]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int s = 0; s < tbl_pkg::DIV_STAGES; s++) begin
        r_q[s+1]    <= ge[s] ? (r2[s] - tbl_pkg::REM_W'(m_in[s])) : r2[s];
        q_q[s+1]    <= {q_in[s][tbl_pkg::Q_W-2:0], ge[s]};
        dmag_q[s+1] <= m_in[s];
      end
      dneg_q[1] <= dneg_i;
      kind_q[1] <= kind_i;
      for (int s = 2; s <= tbl_pkg::DIV_STAGES; s++) begin
        dneg_q[s] <= dneg_q[s-1];
        kind_q[s] <= kind_q[s-1];
      end
    end
  end

  assign kind_o   = kind_q[tbl_pkg::DIV_STAGES];
  assign dneg_o   = dneg_q[tbl_pkg::DIV_STAGES];
  assign quot_o   = q_q[tbl_pkg::DIV_STAGES];
  assign rem_nz_o = (r_q[tbl_pkg::DIV_STAGES] != '0);

endmodule

// ===== src/thermistor_beta_linearizer_top.sv =====
// Channel  Dir  Handshake                  Payload
// s_axis   in   s_axis_tvalid/tready       tdata[11:0] adc_code
// m_axis   out  m_axis_tvalid/tready       tdata[15:0] temp_centi_celsius, tuser[0] clipped
// cfg      in   cfg_valid/cfg_ready        cfg_index (register), cfg_data
//
// One word per cycle in and out while the output is not stalled; the pipe holds the entry stage,
// 122 pipe stages after it, then the output register, a depth set by the
// 40 squarings of the log2 lanes (two stages each) and the 32-stage divider.
// Reset clears valid bits and loads register defaults; no clearing pass.
// A stall freezes the whole pipe only when the output register holds an untaken word
// and the last stage holds another; otherwise the pipe keeps moving.
// Config changes reach the derived constants through registers: T0h and 100*B first, then N from them.
module thermistor_beta_linearizer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [tbl_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,   // [11:0] adc_code
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [tbl_pkg::OUT_W-1:0]           m_axis_tdata_o,   // [15:0] temp_centi_celsius
  output logic [0:0]                          m_axis_tuser_o,   // [0] clipped
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tbl_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tbl_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int LAST = tbl_pkg::PIPE_STAGES - 1;

  // configuration registers and derived constants
  logic [tbl_pkg::RES_W-1:0]  series_q, nominal_q;
  logic [tbl_pkg::BETA_W-1:0] beta_q;
  logic [tbl_pkg::TEMP_W-1:0] t0_q;
  logic signed [16:0]         t0x;
  tbl_pkg::cfg_t              cfg_q;

  // pipeline control
  logic                       v_q [0:LAST];
  logic                       adv;
  logic                       out_valid_q;

  // entry stage
  logic [tbl_pkg::ADC_BITS-1:0] code_d, code_q;
  tbl_pkg::kind_e               kind0_d, kind0_q;
  tbl_pkg::kind_e               kl_q [0:tbl_pkg::LOG_STAGES-1];

  logic [tbl_pkg::LOG_W-1:0]  lg_series, lg_rest, lg_code, lg_nom;
  tbl_pkg::kind_e             kind_sc, kind_dv;
  logic                       dneg_sc, dneg_dv, rem_nz;
  logic [tbl_pkg::DMAG_W-1:0] dmag_sc;
  logic [tbl_pkg::Q_W-1:0]    quot;

  // final conversion
  logic [33:0]                v34;
  logic                       inc;
  logic [tbl_pkg::OUT_W-1:0]  temp_d, temp_q;
  logic                       clip_d, clip_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      series_q  <= tbl_pkg::SERIES_RST;
      nominal_q <= tbl_pkg::NOMINAL_RST;
      beta_q    <= tbl_pkg::BETA_RST;
      t0_q      <= tbl_pkg::T0_RST;
    end else if (cfg_valid_i) begin
      case (tbl_pkg::reg_idx_e'(cfg_index_i))
        tbl_pkg::REG_SERIES:  series_q  <= cfg_data_i;
        tbl_pkg::REG_NOMINAL: nominal_q <= cfg_data_i;
        tbl_pkg::REG_BETA:    beta_q    <= cfg_data_i[tbl_pkg::BETA_W-1:0];
        tbl_pkg::REG_T0:      t0_q      <= cfg_data_i[tbl_pkg::TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // T0 in hundredths of a kelvin, 100*B, and numerator N = 100*B*T0h
  assign t0x = 17'(signed'(t0_q)) * 17'sd100 + 17'sd27315;

  always_ff @(posedge clk_i) begin
    cfg_q.t0h  <= t0x[tbl_pkg::T0H_W-1:0];
    cfg_q.b100 <= tbl_pkg::B100_W'(beta_q) * tbl_pkg::B100_W'(100);
    cfg_q.num  <= tbl_pkg::NUM_W'(cfg_q.b100) * tbl_pkg::NUM_W'(cfg_q.t0h);
  end

  // advance unless the output holds an untaken word and the last stage is full
  assign adv             = !(v_q[LAST] && out_valid_q && !m_axis_tready_i);
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= LAST; s++) v_q[s] <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        v_q[0] <= s_axis_tvalid_i;
        for (int s = 1; s <= LAST; s++) v_q[s] <= v_q[s-1];
      end
      if (adv && v_q[LAST]) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // entry: code zero counts as one; full scale or zero constants give zero ohms
  always_comb begin
    code_d = s_axis_tdata_i[tbl_pkg::ADC_BITS-1:0];
    if (code_d == '0) code_d = tbl_pkg::ADC_BITS'(1);
    if (code_d == tbl_pkg::FULL_CODE || series_q == '0 || nominal_q == '0 || beta_q == '0) begin
      kind0_d = tbl_pkg::KIND_ZERO_R;
    end else begin
      kind0_d = tbl_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      code_q  <= code_d;
      kind0_q <= kind0_d;
      kl_q[0] <= kind0_q;
      for (int s = 1; s < tbl_pkg::LOG_STAGES; s++) kl_q[s] <= kl_q[s-1];
    end
  end

  tbl_log_lane u_lg_series (
    .clk_i (clk_i), .adv_i (adv),
    .op_i  (series_q),
    .log_o (lg_series)
  );

  tbl_log_lane u_lg_rest (
    .clk_i (clk_i), .adv_i (adv),
    .op_i  (tbl_pkg::OP_W'(tbl_pkg::FULL_CODE - code_q)),
    .log_o (lg_rest)
  );

  tbl_log_lane u_lg_code (
    .clk_i (clk_i), .adv_i (adv),
    .op_i  (tbl_pkg::OP_W'(code_q)),
    .log_o (lg_code)
  );

  tbl_log_lane u_lg_nom (
    .clk_i (clk_i), .adv_i (adv),
    .op_i  (nominal_q),
    .log_o (lg_nom)
  );

  tbl_scale u_scale (
    .clk_i       (clk_i),
    .adv_i       (adv),
    .cfg_i       (cfg_q),
    .kind_i      (kl_q[tbl_pkg::LOG_STAGES-1]),
    .lg_series_i (lg_series),
    .lg_rest_i   (lg_rest),
    .lg_code_i   (lg_code),
    .lg_nom_i    (lg_nom),
    .kind_o      (kind_sc),
    .dneg_o      (dneg_sc),
    .dmag_o      (dmag_sc)
  );

  tbl_div u_div (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .num_i    (cfg_q.num),
    .kind_i   (kind_sc),
    .dneg_i   (dneg_sc),
    .dmag_i   (dmag_sc),
    .kind_o   (kind_dv),
    .dneg_o   (dneg_dv),
    .quot_o   (quot),
    .rem_nz_o (rem_nz)
  );

  // kelvin to Celsius, truncate toward zero, saturate to int16
  always_comb begin
    inc = rem_nz && (quot < tbl_pkg::Q_W'(tbl_pkg::KELVIN_CENTI));
    if (dneg_dv) begin
      v34 = 34'd0 - 34'(quot) - 34'(tbl_pkg::KELVIN_CENTI);
    end else begin
      v34 = 34'(quot) - 34'(tbl_pkg::KELVIN_CENTI) + 34'(inc);
    end
    temp_d = v34[tbl_pkg::OUT_W-1:0];
    clip_d = 1'b0;
    if (!v34[33] && v34[32:15] != '0) begin
      temp_d = 16'h7FFF;
      clip_d = 1'b1;
    end else if (v34[33] && v34[32:15] != '1) begin
      temp_d = 16'h8000;
      clip_d = 1'b1;
    end
    case (kind_dv)
      tbl_pkg::KIND_ZERO_R: begin
        temp_d = tbl_pkg::OUT_W'(-tbl_pkg::KELVIN_CENTI);
        clip_d = 1'b0;
      end
      tbl_pkg::KIND_DZERO, tbl_pkg::KIND_OVF_POS: begin
        temp_d = 16'h7FFF;
        clip_d = 1'b1;
      end
      tbl_pkg::KIND_OVF_NEG: begin
        temp_d = 16'h8000;
        clip_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv && v_q[LAST]) begin
      temp_q <= temp_d;
      clip_q <= clip_d;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = temp_q;
  assign m_axis_tuser_o[0] = clip_q;

`ifndef SYNTH
  a_clip_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && clip_q) |-> (temp_q == 16'h7FFF || temp_q == 16'h8000))
    else $error("clipped word does not hold a saturated value");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[LAST] && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while the pipe is frozen");

  a_last_stage_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && v_q[LAST]) |=> out_valid_q)
    else $error("word from last stage did not reach the output register");
`endif

endmodule

// ===== verif/tb_thermistor_beta_linearizer_top.sv =====
module tb_thermistor_beta_linearizer_top;

  localparam int LATENCY_WAIT = 200;
  localparam int CYCLE_LIMIT  = 1500000;

  typedef struct {
    logic [15:0] temp;
    logic        clip;
  } temp_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [tbl_pkg::IN_TDATA_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [tbl_pkg::OUT_W-1:0] m_axis_tdata_o;
  logic [0:0] m_axis_tuser_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [tbl_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [tbl_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  thermistor_beta_linearizer_top dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Our own copy of the register file
  logic [19:0] series_r = 20'd10000;
  logic [19:0] nominal_r = 20'd10000;
  logic [15:0] beta_r = 16'd3950;
  logic [7:0]  t0_r = 8'd25;

  logic [11:0] code_queue[$];
  temp_word_t  temp_expected[$];
  int errors = 0;
  int words_checked = 0;
  int clipped_seen = 0;
  longint cycle = 0;
  bit stimulus_done = 0;
  bit rx_hold = 0;
  int tx_gap = 0;
  int rx_gap = 0;

  function automatic logic [127:0] mul64(logic [63:0] a, logic [63:0] b);
    return {64'd0, a} * {64'd0, b};
  endfunction

  // log2 with 40 fraction bits, by repeated squaring of a Q62 mantissa
  function automatic longint log2_frac40(logic [31:0] n);
    int k;
    logic [63:0] m;
    logic [63:0] frac;
    logic [127:0] p;
    k = 0;
    frac = 0;
    if (n == 0) n = 1;
    while (k < 31 && (n >> (k + 1)) != 0) k++;
    m = 64'(n) << (62 - k);
    for (int i = 0; i < 40; i++) begin
      p = mul64(m, m);
      m = p[125:62];
      frac = frac << 1;
      if (m[63]) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return longint'((64'(k) << 40) | frac);
  endfunction

  function automatic temp_word_t saturate_temp(longint v);
    temp_word_t w;
    w.clip = 1'b0;
    if (v > 32767) begin
      v = 32767;
      w.clip = 1'b1;
    end
    if (v < -32768) begin
      v = -32768;
      w.clip = 1'b1;
    end
    w.temp = v[15:0];
    return w;
  endfunction

  function automatic temp_word_t code_to_centi(logic [11:0] code);
    logic [31:0] c;
    longint lsum, x, t0, t0h, d, v;
    logic [63:0] mag, n, q, r;
    logic [127:0] p;
    logic [64:0] rw;
    bit neg;
    c = code;
    if (c == 0) c = 1;
    if (c >= 4095 || series_r == 0 || nominal_r == 0 || beta_r == 0)
      return saturate_temp(-tbl_pkg::KELVIN_CENTI);
    lsum = log2_frac40(series_r) + log2_frac40(4095 - c)
         - log2_frac40(c) - log2_frac40(nominal_r);
    neg = lsum < 0;
    mag = neg ? 64'(-lsum) : 64'(lsum);
    p = mul64(mag, tbl_pkg::LN2_Q64);
    x = longint'(p[127:64] >> 8);
    if (neg) x = -x;
    t0 = longint'($signed(t0_r));
    t0h = 100 * t0 + tbl_pkg::KELVIN_CENTI;
    n = 64'd100 * 64'(beta_r) * 64'(t0h);
    d = x * t0h + longint'((64'd100 * 64'(beta_r)) << 32);
    if (d == 0) return saturate_temp(32768);
    mag = d > 0 ? 64'(d) : 64'(-d);
    if (n / mag != 0) return saturate_temp(d > 0 ? 32768 : -32769);
    r = n;
    q = 0;
    for (int i = 0; i < 32; i++) begin
      rw = {r, 1'b0};
      q = q << 1;
      if (rw >= {1'b0, mag}) begin
        rw = rw - {1'b0, mag};
        q[0] = 1'b1;
      end
      r = rw[63:0];
    end
    if (d > 0) begin
      v = longint'(q) - tbl_pkg::KELVIN_CENTI;
      if (v < 0 && r != 0) v += 1;
    end else begin
      v = -longint'(q) - tbl_pkg::KELVIN_CENTI;
    end
    return saturate_temp(v);
  endfunction

  // Driver: offer codes from the queue, with random gaps
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      temp_expected.push_back(code_to_centi(s_axis_tdata_i[11:0]));
      void'(code_queue.pop_front());
    end
    if (tx_gap > 0) begin
      tx_gap <= tx_gap - 1;
      s_axis_tvalid_i <= 1'b0;
    end else if (code_queue.size() > 0 && rst_ni) begin
      if (!(s_axis_tvalid_i && !s_axis_tready_o) && $urandom_range(0, 99) < 15) begin
        tx_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        s_axis_tvalid_i <= 1'b0;
      end else begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= tbl_pkg::IN_TDATA_W'(code_queue[0]);
      end
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  // Monitor: check each taken word against the oldest prediction
  always @(posedge clk_i) begin
    temp_word_t w;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (temp_expected.size() == 0) begin
        $error("unexpected word temp=%0d", $signed(m_axis_tdata_o));
        errors++;
      end else begin
        w = temp_expected.pop_front();
        words_checked++;
        if (w.clip) clipped_seen++;
        if (m_axis_tdata_o !== w.temp) begin
          $error("temp_centi_celsius expected %0d got %0d", $signed(w.temp),
                 $signed(m_axis_tdata_o));
          errors++;
        end
        if (m_axis_tuser_o[0] !== w.clip) begin
          $error("clipped expected %0b got %0b", w.clip, m_axis_tuser_o[0]);
          errors++;
        end
      end
    end
    if (rx_hold) m_axis_tready_i <= 1'b0;
    else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      m_axis_tready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < 15) begin
      rx_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(tbl_pkg::reg_idx_e idx, logic [19:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      tbl_pkg::REG_SERIES:  series_r = val;
      tbl_pkg::REG_NOMINAL: nominal_r = val;
      tbl_pkg::REG_BETA:    beta_r = val[15:0];
      default:              t0_r = val[7:0];
    endcase
    @(posedge clk_i);
  endtask

  // Wait until every predicted word has been taken
  task automatic drain();
    while (code_queue.size() != 0 || s_axis_tvalid_i || temp_expected.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_all(logic [19:0] s, logic [19:0] nm, logic [15:0] b, logic [7:0] t);
    write_reg(tbl_pkg::REG_SERIES, s);
    write_reg(tbl_pkg::REG_NOMINAL, nm);
    write_reg(tbl_pkg::REG_BETA, 20'(b));
    write_reg(tbl_pkg::REG_T0, 20'(t));
  endtask

  // Bias toward codes near the ends of the range where the math gets odd
  function automatic logic [11:0] random_code();
    case ($urandom_range(0, 5))
      0: return 12'($urandom_range(0, 8));
      1: return 12'($urandom_range(4086, 4095));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin
    int n_per;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset registers, code extremes and single bits
    foreach (code_queue[i]) ;
    code_queue.push_back(12'd0);
    code_queue.push_back(12'd1);
    code_queue.push_back(12'd4095);
    code_queue.push_back(12'd4094);
    code_queue.push_back(12'd2048);
    code_queue.push_back(12'hAAA);
    code_queue.push_back(12'h555);
    for (int b = 0; b < 12; b++) code_queue.push_back(12'(1 << b));
    drain();

    // Zero resistors and beta give the kelvin-offset result
    write_reg(tbl_pkg::REG_SERIES, 20'd0);
    code_queue.push_back(12'd100);
    drain();
    set_all(20'd10000, 20'd0, 16'd3950, 8'd25);
    code_queue.push_back(12'd100);
    drain();
    set_all(20'd10000, 20'd10000, 16'd0, 8'd25);
    code_queue.push_back(12'd100);
    drain();

    // Random phases over several settings, extremes included
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_all(20'd10000, 20'd10000, 16'd3950, 8'd25);
        1: set_all(20'hFFFFF, 20'd1, 16'd1, 8'sd125);
        2: set_all(20'd1, 20'hFFFFF, 16'hFFFF, -8'sd40);
        3: set_all(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 8'sd125);
        4: set_all(20'd1, 20'd1, 16'd1, -8'sd40);
        5: set_all(20'd100000, 20'd100000, 16'd4250, 8'd0);
        6: set_all(20'd4700, 20'd1000, 16'd20, 8'hFF);
        default: set_all(20'($urandom_range(1, 20'hFFFFF)), 20'($urandom_range(1, 20'hFFFFF)),
                         16'($urandom_range(1, 16'hFFFF)), 8'($urandom_range(0, 255)));
      endcase
      n_per = 115;
      if (ph == 2) begin
        // Hold the receiver long enough that the pipe fills and stalls input
        n_per = 200;
        rx_hold = 1;
        for (int i = 0; i < n_per; i++) code_queue.push_back(random_code());
        repeat (400) @(posedge clk_i);
        rx_hold = 0;
      end else begin
        for (int i = 0; i < n_per; i++) code_queue.push_back(random_code());
      end
      drain();
    end
    stimulus_done = 1;
    repeat (LATENCY_WAIT) @(posedge clk_i);
    $display("Checked %0d words over 13 register settings, %0d clipped.",
             words_checked, clipped_seen);
    if (errors == 0 && temp_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
